### src/vrhp_pkg.sv
// Package for the request header parser: phase codes, state, configuration
// and result types, header layout constants and the address length helper.
// Depends on nothing; vrhp_step, the top level and the testbench use it.
package vrhp_pkg;

	typedef enum logic [3:0] {
		PH_VERSION  = 4'd0,
		PH_USER_ID  = 4'd1,
		PH_ADDON    = 4'd2,
		PH_COMMAND  = 4'd3,
		PH_PORT     = 4'd4,
		PH_ATYPE    = 4'd5,
		PH_DOMLEN   = 4'd6,
		PH_ADDRESS  = 4'd7,
		PH_TRAILING = 4'd8,
		PH_ERROR    = 4'd9
	} phase_t;

	localparam logic [2:0] CFG_VERSION = 3'd0;
	localparam logic [2:0] CFG_TCP     = 3'd1;
	localparam logic [2:0] CFG_UDP     = 3'd2;
	localparam logic [2:0] CFG_MUX     = 3'd3;
	localparam logic [2:0] CFG_IPV4    = 3'd4;
	localparam logic [2:0] CFG_DOMAIN  = 3'd5;
	localparam logic [2:0] CFG_IPV6    = 3'd6;

	localparam logic [1:0] CMD_TCP = 2'd0;
	localparam logic [1:0] CMD_UDP = 2'd1;
	localparam logic [1:0] CMD_MUX = 2'd2;

	localparam logic [1:0] ADDR_IPV4   = 2'd0;
	localparam logic [1:0] ADDR_DOMAIN = 2'd1;
	localparam logic [1:0] ADDR_IPV6   = 2'd2;

	localparam logic [8:0] MIN_FRAME_BYTES = 9'd26;
	localparam logic [8:0] COUNT_MAX       = 9'd511;
	localparam logic [7:0] USER_ID_BYTES   = 8'd16;
	localparam logic [7:0] IPV4_BYTES      = 8'd4;
	localparam logic [7:0] IPV6_BYTES      = 8'd16;
	localparam logic [7:0] INDEX_MAX       = 8'd255;

	typedef struct packed {
		logic [7:0] version_code;
		logic [7:0] tcp_command_code;
		logic [7:0] udp_command_code;
		logic [7:0] mux_command_code;
		logic [7:0] ipv4_type_code;
		logic [7:0] domain_type_code;
		logic [7:0] ipv6_type_code;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		version_code:     8'd0,
		tcp_command_code: 8'd1,
		udp_command_code: 8'd2,
		mux_command_code: 8'd3,
		ipv4_type_code:   8'd1,
		domain_type_code: 8'd2,
		ipv6_type_code:   8'd3
	};

	typedef struct packed {
		phase_t      phase;
		logic [8:0]  byte_count;
		logic [7:0]  field_pos;
		logic [7:0]  dom_len;
		logic        rejected;
		logic        addr_done;
		logic [1:0]  cmd;
		logic [1:0]  akind;
		logic [15:0] port;
	} state_t;

	localparam state_t STATE_RESET = '{
		phase:      PH_VERSION,
		byte_count: 9'd0,
		field_pos:  8'd0,
		dom_len:    8'd0,
		rejected:   1'b0,
		addr_done:  1'b0,
		cmd:        2'd0,
		akind:      2'd0,
		port:       16'd0
	};

	typedef struct packed {
		logic [7:0]  byte_out;
		logic [3:0]  field_kind;
		logic [7:0]  field_index;
		logic        done_res;
		logic        accepted;
		logic [1:0]  command_kind;
		logic        is_datagram;
		logic [1:0]  address_kind;
		logic [15:0] dest_port;
		logic [7:0]  address_length;
	} result_t;

	function automatic logic [7:0] addr_len(input logic [1:0] akind, input logic [7:0] dom_len);
		logic [7:0] len;
		if (akind == ADDR_IPV4) begin
			len = IPV4_BYTES;
		end else if (akind == ADDR_IPV6) begin
			len = IPV6_BYTES;
		end else begin
			len = dom_len;
		end
		return len;
	endfunction

endpackage

### src/vrhp_in_if.sv
// Input channel of the request header parser: one frame byte per transfer.
// Depends on nothing.
interface vrhp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

### src/vrhp_out_if.sv
// Result channel of the request header parser: one tagged byte per transfer.
// Depends on nothing.
interface vrhp_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_out;
	logic [3:0]  field_kind;
	logic [7:0]  field_index;
	logic        done_res;
	logic        accepted;
	logic [1:0]  command_kind;
	logic        is_datagram;
	logic [1:0]  address_kind;
	logic [15:0] dest_port;
	logic [7:0]  address_length;

	modport source (
		output valid, output byte_out, output field_kind, output field_index,
		output done_res, output accepted, output command_kind, output is_datagram,
		output address_kind, output dest_port, output address_length, input ready
	);
	modport sink (
		input valid, input byte_out, input field_kind, input field_index,
		input done_res, input accepted, input command_kind, input is_datagram,
		input address_kind, input dest_port, input address_length, output ready
	);
endinterface

### src/vless_request_header_parser_top.sv
// Top level of the request header parser: configuration registers, parse
// state and the result register. Depends on vrhp_pkg, vrhp_in_if,
// vrhp_out_if and vrhp_step.
//
// Usage: frame bytes arrive on the hdr channel, one per transfer, with last
// set on the final byte of a frame. For each byte one result leaves on the
// res channel: the byte itself, its field tag and its index in that field.
// The result for the last byte also carries the verdict and, when accepted,
// the command, address kind, port and address length.
// An input transfer's result is registered and valid in the cycle after it.
// One byte is taken per cycle unless the receiver stalls; the parse state
// update for a byte is a single pass through the step logic, and the result
// register lets a new byte be taken in the same cycle that the held result
// is transferred. If the receiver stalls, the held result stays put and
// hdr.ready drops until it is taken. Reset empties the result register, puts
// the parser at the version byte and loads the default type codes. The user
// makes configuration writes (cfg_we, cfg_index, cfg_data) while no frame is
// in progress, unenforced by the block; an index beyond the last register is ignored.
module vless_request_header_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	vrhp_in_if.sink    hdr,
	vrhp_out_if.source res,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	vrhp_pkg::cfg_t    cfg_q;
	vrhp_pkg::state_t  state_q;
	vrhp_pkg::state_t  state_nxt;
	vrhp_pkg::result_t res_nxt;
	vrhp_pkg::result_t res_s1;
	logic              res_valid_q;
	logic              hdr_xfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= vrhp_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vrhp_pkg::CFG_VERSION: cfg_q.version_code     <= cfg_data;
				vrhp_pkg::CFG_TCP:     cfg_q.tcp_command_code <= cfg_data;
				vrhp_pkg::CFG_UDP:     cfg_q.udp_command_code <= cfg_data;
				vrhp_pkg::CFG_MUX:     cfg_q.mux_command_code <= cfg_data;
				vrhp_pkg::CFG_IPV4:    cfg_q.ipv4_type_code   <= cfg_data;
				vrhp_pkg::CFG_DOMAIN:  cfg_q.domain_type_code <= cfg_data;
				vrhp_pkg::CFG_IPV6:    cfg_q.ipv6_type_code   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign hdr.ready = !res_valid_q || res.ready;
	assign hdr_xfer  = hdr.valid && hdr.ready;

	vrhp_step u_step (
		.cur       (state_q),
		.cfg       (cfg_q),
		.data_byte (hdr.data_byte),
		.last      (hdr.last),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vrhp_pkg::STATE_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (hdr_xfer) begin
				state_q <= state_nxt;
			end
			if (hdr_xfer) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_xfer) begin
			res_s1 <= res_nxt;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.byte_out       = res_s1.byte_out;
	assign res.field_kind     = res_s1.field_kind;
	assign res.field_index    = res_s1.field_index;
	assign res.done_res       = res_s1.done_res;
	assign res.accepted       = res_s1.accepted;
	assign res.command_kind   = res_s1.command_kind;
	assign res.is_datagram    = res_s1.is_datagram;
	assign res.address_kind   = res_s1.address_kind;
	assign res.dest_port      = res_s1.dest_port;
	assign res.address_length = res_s1.address_length;

endmodule

### src/vrhp_step.sv
// Per-byte next-state and result logic of the request header parser.
// Depends on vrhp_pkg.
module vrhp_step (
	input  vrhp_pkg::state_t  cur,
	input  vrhp_pkg::cfg_t    cfg,
	input  logic [7:0]        data_byte,
	input  logic              last,
	output vrhp_pkg::state_t  nxt,
	output vrhp_pkg::result_t res
);

	vrhp_pkg::state_t upd;
	logic             fail;
	logic [8:0]       pos_inc;
	logic             ok;

	always_comb begin
		upd     = cur;
		fail    = 1'b0;
		pos_inc = {1'b0, cur.field_pos} + 9'd1;
		if (cur.byte_count != vrhp_pkg::COUNT_MAX) begin
			upd.byte_count = cur.byte_count + 9'd1;
		end
		unique case (cur.phase)
			vrhp_pkg::PH_VERSION: begin
				if (data_byte != cfg.version_code) begin
					fail = 1'b1;
				end else begin
					upd.phase     = vrhp_pkg::PH_USER_ID;
					upd.field_pos = 8'd0;
				end
			end
			vrhp_pkg::PH_USER_ID: begin
				if (pos_inc >= {1'b0, vrhp_pkg::USER_ID_BYTES}) begin
					upd.phase     = vrhp_pkg::PH_ADDON;
					upd.field_pos = 8'd0;
				end else begin
					upd.field_pos = pos_inc[7:0];
				end
			end
			vrhp_pkg::PH_ADDON: begin
				if (data_byte != 8'd0) begin
					fail = 1'b1;
				end else begin
					upd.phase = vrhp_pkg::PH_COMMAND;
				end
			end
			vrhp_pkg::PH_COMMAND: begin
				// Duplicate codes resolve in the order tcp, udp, mux.
				if (data_byte == cfg.tcp_command_code) begin
					upd.cmd = vrhp_pkg::CMD_TCP;
				end else if (data_byte == cfg.udp_command_code) begin
					upd.cmd = vrhp_pkg::CMD_UDP;
				end else if (data_byte == cfg.mux_command_code) begin
					upd.cmd = vrhp_pkg::CMD_MUX;
				end else begin
					fail = 1'b1;
				end
				if (!fail) begin
					upd.phase     = vrhp_pkg::PH_PORT;
					upd.field_pos = 8'd0;
				end
			end
			vrhp_pkg::PH_PORT: begin
				if (cur.field_pos == 8'd0) begin
					upd.port      = {data_byte, 8'd0};
					upd.field_pos = 8'd1;
				end else begin
					upd.port      = {cur.port[15:8], cur.port[7:0] | data_byte};
					upd.phase     = vrhp_pkg::PH_ATYPE;
					upd.field_pos = 8'd0;
				end
			end
			vrhp_pkg::PH_ATYPE: begin
				upd.field_pos = 8'd0;
				if (data_byte == cfg.ipv4_type_code) begin
					upd.akind = vrhp_pkg::ADDR_IPV4;
					upd.phase = vrhp_pkg::PH_ADDRESS;
				end else if (data_byte == cfg.domain_type_code) begin
					upd.akind = vrhp_pkg::ADDR_DOMAIN;
					upd.phase = vrhp_pkg::PH_DOMLEN;
				end else if (data_byte == cfg.ipv6_type_code) begin
					upd.akind = vrhp_pkg::ADDR_IPV6;
					upd.phase = vrhp_pkg::PH_ADDRESS;
				end else begin
					fail = 1'b1;
				end
			end
			vrhp_pkg::PH_DOMLEN: begin
				if (data_byte == 8'd0) begin
					fail = 1'b1;
				end else begin
					upd.dom_len   = data_byte;
					upd.phase     = vrhp_pkg::PH_ADDRESS;
					upd.field_pos = 8'd0;
				end
			end
			vrhp_pkg::PH_ADDRESS: begin
				if (pos_inc >= {1'b0, vrhp_pkg::addr_len(cur.akind, cur.dom_len)}) begin
					upd.addr_done = 1'b1;
					upd.phase     = vrhp_pkg::PH_TRAILING;
					upd.field_pos = 8'd0;
				end else begin
					upd.field_pos = pos_inc[7:0];
				end
			end
			default: begin
				// Trailing and after-error bytes: index saturates.
				if (cur.field_pos != vrhp_pkg::INDEX_MAX) begin
					upd.field_pos = pos_inc[7:0];
				end
			end
		endcase
		if (fail) begin
			upd.rejected  = 1'b1;
			upd.phase     = vrhp_pkg::PH_ERROR;
			upd.field_pos = 8'd0;
		end
	end

	assign ok = last && !upd.rejected && upd.addr_done
		&& (upd.byte_count >= vrhp_pkg::MIN_FRAME_BYTES);

	assign nxt = last ? vrhp_pkg::STATE_RESET : upd;

	always_comb begin
		res                = '0;
		res.byte_out       = data_byte;
		res.field_kind     = cur.phase;
		res.field_index    = cur.field_pos;
		res.done_res       = last;
		if (ok) begin
			res.accepted       = 1'b1;
			res.command_kind   = upd.cmd;
			res.is_datagram    = (upd.cmd == vrhp_pkg::CMD_UDP);
			res.address_kind   = upd.akind;
			res.dest_port      = upd.port;
			res.address_length = vrhp_pkg::addr_len(upd.akind, upd.dom_len);
		end
	end

endmodule

### test/vless_request_header_parser_top_tb.sv
`timescale 1ns / 1ps
// Testbench for vless_request_header_parser_top: request frames go in one byte per transfer,
// and each tagged byte out is checked against a local parser model or a fixed frame's result.
// Depends on vrhp_pkg, the vrhp_in_if and vrhp_out_if interfaces and the parser top level.
module vless_request_header_parser_top_tb;
	import vrhp_pkg::*;

	localparam logic [2:0] CFG_UNUSED = 3'd7;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int CODE_SETS = 5;
	localparam int RANDOM_BYTES_PER_SET = 20;

	localparam logic [7:0] DEF_VERSION = CFG_RESET.version_code;
	localparam logic [7:0] DEF_TCP = CFG_RESET.tcp_command_code;
	localparam logic [7:0] DEF_UDP = CFG_RESET.udp_command_code;
	localparam logic [7:0] DEF_MUX = CFG_RESET.mux_command_code;
	localparam logic [7:0] DEF_IPV4 = CFG_RESET.ipv4_type_code;
	localparam logic [7:0] DEF_DOMAIN = CFG_RESET.domain_type_code;
	localparam logic [7:0] DEF_IPV6 = CFG_RESET.ipv6_type_code;

	localparam result_t NO_RESULT = '0;

	// Recipe for one frame. keep of zero sends the whole frame; fill is the body byte
	// of directed frames. When fixed is set, last_res is the expected result of the
	// final byte.
	typedef struct packed {
		logic [7:0]  version;
		logic [7:0]  addon;
		logic [7:0]  command;
		logic [15:0] port;
		logic [7:0]  atype;
		logic [7:0]  name_len;
		logic [7:0]  fill;
		logic [15:0] keep;
		logic [15:0] trail;
		logic        fixed;
		result_t     last_res;
	} frame_t;

	localparam int DIRECTED_COUNT = 17;
	localparam frame_t DIRECTED_FRAMES [DIRECTED_COUNT] = '{
		// Version byte that matches no register, alone in its frame.
		'{8'hFF, 8'h00, DEF_TCP, 16'h0000, DEF_IPV4, 8'd0, 8'h00, 16'd1, 16'd0, 1'b1,
			'{8'hFF, PH_VERSION, 8'd0, 1'b1, 1'b0, 2'd0, 1'b0, 2'd0, 16'd0, 8'd0}},
		// Good version byte, but the frame ends right there.
		'{DEF_VERSION, 8'h00, DEF_TCP, 16'h0000, DEF_IPV4, 8'd0, 8'h00, 16'd1, 16'd0, 1'b1,
			'{DEF_VERSION, PH_VERSION, 8'd0, 1'b1, 1'b0, 2'd0, 1'b0, 2'd0, 16'd0, 8'd0}},
		'{DEF_VERSION, 8'h00, DEF_TCP, 16'h0000, DEF_IPV4, 8'd0, 8'h00, 16'd0, 16'd0, 1'b1,
			'{8'h00, PH_ADDRESS, 8'd3, 1'b1, 1'b1, CMD_TCP, 1'b0, ADDR_IPV4, 16'h0000,
			IPV4_BYTES}},
		'{DEF_VERSION, 8'h00, DEF_UDP, 16'hFFFF, DEF_IPV6, 8'd0, 8'hFF, 16'd0, 16'd0, 1'b1,
			'{8'hFF, PH_ADDRESS, 8'd15, 1'b1, 1'b1, CMD_UDP, 1'b1, ADDR_IPV6, 16'hFFFF,
			IPV6_BYTES}},
		'{DEF_VERSION, 8'h00, DEF_MUX, 16'h8001, DEF_DOMAIN, 8'd9, 8'hA5, 16'd0, 16'd0, 1'b1,
			'{8'hA5, PH_ADDRESS, 8'd8, 1'b1, 1'b1, CMD_MUX, 1'b0, ADDR_DOMAIN, 16'h8001,
			8'd9}},
		// One-byte domain with nothing after it is two bytes short of a full header.
		'{DEF_VERSION, 8'h00, DEF_TCP, 16'h0101, DEF_DOMAIN, 8'd1, 8'h5A, 16'd0, 16'd0, 1'b1,
			'{8'h5A, PH_ADDRESS, 8'd0, 1'b1, 1'b0, 2'd0, 1'b0, 2'd0, 16'd0, 8'd0}},
		'{DEF_VERSION, 8'h00, DEF_UDP, 16'h1234, DEF_DOMAIN, 8'd1, 8'h3C, 16'd0, 16'd2, 1'b1,
			'{8'h3C, PH_TRAILING, 8'd1, 1'b1, 1'b1, CMD_UDP, 1'b1, ADDR_DOMAIN, 16'h1234,
			8'd1}},
		'{DEF_VERSION, 8'h80, DEF_TCP, 16'h0050, DEF_IPV4, 8'd0, 8'h11, 16'd0, 16'd0, 1'b0,
			NO_RESULT},
		'{DEF_VERSION, 8'h00, 8'hFF, 16'h0050, DEF_IPV4, 8'd0, 8'h22, 16'd0, 16'd1, 1'b0,
			NO_RESULT},
		'{DEF_VERSION, 8'h00, DEF_MUX, 16'h0050, 8'hFF, 8'd0, 8'h33, 16'd0, 16'd3, 1'b0,
			NO_RESULT},
		'{DEF_VERSION, 8'h00, DEF_TCP, 16'h0050, DEF_DOMAIN, 8'd0, 8'h44, 16'd0, 16'd3, 1'b0,
			NO_RESULT},
		// IPv6 address cut off after eight bytes.
		'{DEF_VERSION, 8'h00, DEF_TCP, 16'h0050, DEF_IPV6, 8'd0, 8'h77, 16'd30, 16'd0, 1'b1,
			'{8'h77, PH_ADDRESS, 8'd7, 1'b1, 1'b0, 2'd0, 1'b0, 2'd0, 16'd0, 8'd0}},
		// Long enough for the trailing index to reach its saturation value.
		'{DEF_VERSION, 8'h00, DEF_TCP, 16'h0050, DEF_IPV4, 8'd0, 8'h99, 16'd0, 16'd256, 1'b1,
			'{8'h99, PH_TRAILING, 8'd255, 1'b1, 1'b1, CMD_TCP, 1'b0, ADDR_IPV4, 16'h0050,
			IPV4_BYTES}},
		'{8'h01, 8'h00, DEF_TCP, 16'h0050, DEF_IPV4, 8'd0, 8'hEE, 16'd0, 16'd20, 1'b1,
			'{8'hEE, PH_ERROR, 8'd44, 1'b1, 1'b0, 2'd0, 1'b0, 2'd0, 16'd0, 8'd0}},
		'{DEF_VERSION, 8'h00, DEF_TCP, 16'h0050, DEF_IPV4, 8'd0, 8'h55, 16'd5, 16'd0, 1'b0,
			NO_RESULT},
		'{DEF_VERSION, 8'h00, DEF_TCP, 16'hABCD, DEF_IPV4, 8'd0, 8'h66, 16'd20, 16'd0, 1'b0,
			NO_RESULT},
		'{DEF_VERSION, 8'h00, DEF_MUX, 16'h7FFE, DEF_IPV4, 8'd0, 8'h88, 16'd0, 16'd5, 1'b0,
			NO_RESULT}
	};

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;

	vrhp_in_if  hdr_if ();
	vrhp_out_if res_if ();

	vless_request_header_parser_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr       (hdr_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Local copy of the type codes and of the parse state.
	cfg_t        codes = CFG_RESET;
	phase_t      stage;
	logic [8:0]  seen_bytes;
	logic [7:0]  pos;
	logic [7:0]  name_len;
	logic        bad;
	logic        addr_complete;
	logic [1:0]  cmd_hold;
	logic [1:0]  kind_hold;
	logic [15:0] port_hold;

	result_t due_tags [$];
	int      failures = 0;
	int      sent_count = 0;
	int      idle_cycles = 0;
	bit      tx_burst = 1'b0;
	bit      rx_burst = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void restart_parse();
		stage = PH_VERSION;
		seen_bytes = '0;
		pos = '0;
		name_len = '0;
		bad = 1'b0;
		addr_complete = 1'b0;
		cmd_hold = '0;
		kind_hold = '0;
		port_hold = '0;
	endfunction

	function automatic void mark_rejected();
		bad = 1'b1;
		stage = PH_ERROR;
		pos = '0;
	endfunction

	function automatic logic [7:0] address_span();
		logic [7:0] n;
		case (kind_hold)
			ADDR_IPV4: n = IPV4_BYTES;
			ADDR_IPV6: n = IPV6_BYTES;
			default: n = name_len;
		endcase
		return n;
	endfunction

	// Tags one accepted byte and advances the parse state.
	function automatic result_t tag_byte(input logic [7:0] b, input logic l);
		result_t r;
		r = '0;
		r.byte_out = b;
		r.field_kind = stage;
		r.field_index = pos;
		r.done_res = l;
		if (seen_bytes != COUNT_MAX) seen_bytes = seen_bytes + 9'd1;
		case (stage)
			PH_VERSION: begin
				if (b != codes.version_code) begin
					mark_rejected();
				end else begin
					stage = PH_USER_ID;
					pos = '0;
				end
			end
			PH_USER_ID: begin
				pos = pos + 8'd1;
				if (pos >= USER_ID_BYTES) begin
					stage = PH_ADDON;
					pos = '0;
				end
			end
			PH_ADDON: begin
				if (b != 8'h00) mark_rejected();
				else stage = PH_COMMAND;
			end
			PH_COMMAND: begin
				// Equal codes resolve in the order tcp, udp, mux.
				if (b == codes.tcp_command_code || b == codes.udp_command_code ||
						b == codes.mux_command_code) begin
					if (b == codes.tcp_command_code) cmd_hold = CMD_TCP;
					else if (b == codes.udp_command_code) cmd_hold = CMD_UDP;
					else cmd_hold = CMD_MUX;
					stage = PH_PORT;
					pos = '0;
				end else begin
					mark_rejected();
				end
			end
			PH_PORT: begin
				if (pos == 8'd0) begin
					port_hold = {b, 8'h00};
					pos = 8'd1;
				end else begin
					port_hold[7:0] = b;
					stage = PH_ATYPE;
					pos = '0;
				end
			end
			PH_ATYPE: begin
				if (b == codes.ipv4_type_code) begin
					kind_hold = ADDR_IPV4;
					stage = PH_ADDRESS;
					pos = '0;
				end else if (b == codes.domain_type_code) begin
					kind_hold = ADDR_DOMAIN;
					stage = PH_DOMLEN;
					pos = '0;
				end else if (b == codes.ipv6_type_code) begin
					kind_hold = ADDR_IPV6;
					stage = PH_ADDRESS;
					pos = '0;
				end else begin
					mark_rejected();
				end
			end
			PH_DOMLEN: begin
				if (b == 8'h00) begin
					mark_rejected();
				end else begin
					name_len = b;
					stage = PH_ADDRESS;
					pos = '0;
				end
			end
			PH_ADDRESS: begin
				pos = pos + 8'd1;
				if (pos >= address_span()) begin
					addr_complete = 1'b1;
					stage = PH_TRAILING;
					pos = '0;
				end
			end
			default: begin
				if (pos != INDEX_MAX) pos = pos + 8'd1;
			end
		endcase
		if (l) begin
			if (!bad && addr_complete && seen_bytes >= MIN_FRAME_BYTES) begin
				r.accepted = 1'b1;
				r.command_kind = cmd_hold;
				r.is_datagram = (cmd_hold == CMD_UDP);
				r.address_kind = kind_hold;
				r.dest_port = port_hold;
				r.address_length = address_span();
			end
			restart_parse();
		end
		return r;
	endfunction

	task automatic write_code(input logic [2:0] idx, input logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			CFG_VERSION: codes.version_code = value;
			CFG_TCP: codes.tcp_command_code = value;
			CFG_UDP: codes.udp_command_code = value;
			CFG_MUX: codes.mux_command_code = value;
			CFG_IPV4: codes.ipv4_type_code = value;
			CFG_DOMAIN: codes.domain_type_code = value;
			CFG_IPV6: codes.ipv6_type_code = value;
			default: ;
		endcase
	endtask

	// Codes change only between frames, once every tagged byte has been taken.
	task automatic load_codes(input cfg_t s);
		hdr_if.valid <= 1'b0;
		while (due_tags.size() != 0) @(posedge clk);
		write_code(CFG_VERSION, s.version_code);
		write_code(CFG_TCP, s.tcp_command_code);
		write_code(CFG_UDP, s.udp_command_code);
		write_code(CFG_MUX, s.mux_command_code);
		write_code(CFG_IPV4, s.ipv4_type_code);
		write_code(CFG_DOMAIN, s.domain_type_code);
		write_code(CFG_IPV6, s.ipv6_type_code);
		write_code(CFG_UNUSED, 8'($urandom));
		cfg_we <= 1'b0;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic l, input bit fixed,
			input result_t fixed_res);
		int gap;
		result_t r;
		gap = tx_burst ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			hdr_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hdr_if.valid <= 1'b1;
		hdr_if.data_byte <= b;
		hdr_if.last <= l;
		do @(posedge clk); while (!hdr_if.ready);
		r = tag_byte(b, l);
		due_tags.insert(due_tags.size(), fixed ? fixed_res : r);
		sent_count++;
	endtask

	task automatic send_frame(input frame_t f, input bit random_body);
		logic [7:0] bytes [$];
		int span;
		bytes = {};
		bytes.insert(bytes.size(), f.version);
		repeat (USER_ID_BYTES) bytes.insert(bytes.size(), random_body ? 8'($urandom) : f.fill);
		bytes.insert(bytes.size(), f.addon);
		bytes.insert(bytes.size(), f.command);
		bytes.insert(bytes.size(), f.port[15:8]);
		bytes.insert(bytes.size(), f.port[7:0]);
		bytes.insert(bytes.size(), f.atype);
		span = 0;
		if (f.atype == codes.ipv4_type_code) begin
			span = IPV4_BYTES;
		end else if (f.atype == codes.domain_type_code) begin
			bytes.insert(bytes.size(), f.name_len);
			span = f.name_len;
		end else if (f.atype == codes.ipv6_type_code) begin
			span = IPV6_BYTES;
		end
		repeat (span + f.trail)
			bytes.insert(bytes.size(), random_body ? 8'($urandom) : f.fill);
		if (f.keep != 0 && f.keep < bytes.size()) bytes = bytes[0:f.keep - 1];
		tx_burst = ($urandom_range(0, 4) == 0);
		foreach (bytes[i]) begin
			send_byte(bytes[i], i == bytes.size() - 1, f.fixed && i == bytes.size() - 1,
				f.last_res);
		end
	endtask

	// Mostly well-formed frames under the current codes, with some broken ones mixed in.
	function automatic frame_t random_frame();
		frame_t f;
		int unsigned sel;
		f = '0;
		f.version = ($urandom_range(0, 15) == 0) ? 8'($urandom) : codes.version_code;
		f.addon = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'h00;
		sel = $urandom_range(0, 12);
		if (sel < 4) f.command = codes.tcp_command_code;
		else if (sel < 8) f.command = codes.udp_command_code;
		else if (sel < 12) f.command = codes.mux_command_code;
		else f.command = 8'($urandom);
		sel = $urandom_range(0, 12);
		if (sel < 4) f.atype = codes.ipv4_type_code;
		else if (sel < 8) f.atype = codes.domain_type_code;
		else if (sel < 12) f.atype = codes.ipv6_type_code;
		else f.atype = 8'($urandom);
		sel = $urandom_range(0, 15);
		if (sel == 0) f.name_len = 8'h00;
		else if (sel == 1) f.name_len = 8'($urandom);
		else f.name_len = 8'($urandom_range(1, 12));
		f.port = 16'($urandom);
		f.trail = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 40))
			: 16'($urandom_range(0, 4));
		f.keep = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 40)) : 16'd0;
		return f;
	endfunction

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			failures++;
		end
	endtask

	task automatic check_tag(input result_t got);
		result_t want;
		if (due_tags.size() == 0) begin
			$error("result transfer with no byte outstanding: byte_out %0h", got.byte_out);
			failures++;
		end else begin
			want = due_tags.pop_front();
			compare_field("byte_out", want.byte_out, got.byte_out);
			compare_field("field_kind", want.field_kind, got.field_kind);
			compare_field("field_index", want.field_index, got.field_index);
			compare_field("done_res", want.done_res, got.done_res);
			compare_field("accepted", want.accepted, got.accepted);
			compare_field("command_kind", want.command_kind, got.command_kind);
			compare_field("is_datagram", want.is_datagram, got.is_datagram);
			compare_field("address_kind", want.address_kind, got.address_kind);
			compare_field("dest_port", want.dest_port, got.dest_port);
			compare_field("address_length", want.address_length, got.address_length);
		end
	endtask

	initial begin : result_sink
		int stall;
		int taken;
		taken = 0;
		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
			stall = rx_burst ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (res_if.valid !== 1'b1);
			check_tag({res_if.byte_out, res_if.field_kind, res_if.field_index,
				res_if.done_res, res_if.accepted, res_if.command_kind, res_if.is_datagram,
				res_if.address_kind, res_if.dest_port, res_if.address_length});
			taken++;
		end
	end

	// Ends the run when neither channel has seen a transfer for too long.
	always @(posedge clk) begin
		if ((hdr_if.valid && hdr_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
		else idle_cycles = idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("vless_request_header_parser_top test failed");
			$finish;
		end
	end

	initial begin : stimulus
		cfg_t code_sets [CODE_SETS];
		int mark;
		arst_n <= 1'b0;
		hdr_if.valid <= 1'b0;
		hdr_if.data_byte <= '0;
		hdr_if.last <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_VERSION;
		cfg_data <= '0;
		restart_parse();

		// Extremes first, then random codes, one set with shared codes to exercise
		// the precedence between equal values, and a last random set.
		code_sets[0] = '0;
		code_sets[1] = '1;
		code_sets[2] = cfg_t'({$urandom, 24'($urandom)});
		code_sets[3] = cfg_t'({$urandom, 24'($urandom)});
		code_sets[3].mux_command_code = code_sets[3].udp_command_code;
		code_sets[3].ipv6_type_code = code_sets[3].domain_type_code;
		code_sets[4] = cfg_t'({$urandom, 24'($urandom)});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_FRAMES[i]) send_frame(DIRECTED_FRAMES[i], 1'b0);

		foreach (code_sets[i]) begin
			load_codes(code_sets[i]);
			mark = sent_count;
			while (sent_count - mark < RANDOM_BYTES_PER_SET) send_frame(random_frame(), 1'b1);
		end

		hdr_if.valid <= 1'b0;
		while (due_tags.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("vless_request_header_parser_top test passed");
		end else begin
			$display("vless_request_header_parser_top test failed");
		end
		$finish;
	end

endmodule

### vless_request_header_parser_top.f
src/vrhp_pkg.sv
src/vrhp_in_if.sv
src/vrhp_out_if.sv
src/vrhp_step.sv
src/vless_request_header_parser_top.sv
test/vless_request_header_parser_top_tb.sv
